// ----- rtl/msaf_pkg.sv -----
// shared types, constants and codes for the mqtt session filter
package msaf_pkg;

    // session table
    localparam int SESSIONS   = 64;
    localparam int NUM_STATES = 8;
    localparam int STATE_W    = 3;
    localparam int SESS_AW    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int SESS_CW    = $clog2(SESSIONS + 1);

    // frame parsing
    localparam int POS_W                 = 11;
    localparam logic [POS_W-1:0] POS_MAX = 11'd2047;
    localparam int ETH_TYPE_POS          = 12;
    localparam int IP_PROTO_POS          = 23;
    localparam int SADDR_POS             = 26;
    localparam int DPORT_POS             = 36;
    localparam int TCP_BASE              = 34;
    localparam int TCP_LEN               = 20;
    localparam int TCP_AW                = $clog2(TCP_LEN);
    localparam int DOFF_BYTE             = 12;
    localparam int DOFF_SMALL            = TCP_LEN / 4;

    localparam logic [15:0] IPV4_ETHERTYPE    = 16'h0800;
    localparam logic [7:0]  TCP_PROTOCOL      = 8'd6;
    localparam logic [15:0] MQTT_PORT_DEFAULT = 16'd1883;
    localparam logic [3:0]  MQTT_CONNECT      = 4'd1;
    localparam logic [3:0]  MQTT_PUBLISH      = 4'd3;
    localparam logic [3:0]  MQTT_DISCONNECT   = 4'd14;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_W = 64;

    typedef enum logic [1:0] {
        EV_CONNECT,
        EV_PUBLISH,
        EV_DISCONNECT,
        EV_ERROR
    } t_event;

    typedef enum logic [1:0] {
        CAUSE_UNMONITORED,
        CAUSE_ALLOWED,
        CAUSE_BLOCKED,
        CAUSE_NEW_BLOCK
    } t_cause;

    typedef enum logic [1:0] {
        CFG_TRANS_LOW,
        CFG_TRANS_HIGH,
        CFG_ERROR_STATE,
        CFG_BROKER_PORT
    } t_cfg_idx;

    typedef struct packed {
        logic             we;
        t_cfg_idx         idx;
        logic [CFG_W-1:0] data;
    } t_cfg_write;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_in_item;

    typedef struct packed {
        logic        verdict;
        t_cause      cause;
        logic [31:0] source_addr;
    } t_out_item;

    typedef struct packed {
        logic        track;
        logic [31:0] saddr;
        t_event      ev;
    } t_request;

endpackage

// ----- rtl/mqtt_session_automaton_filter.sv -----
// top level of the per-source mqtt session filter
//
//   channel   direction   handshake                payload
//   in        input       i_in_valid / o_in_stall  i_in_data  (frame_byte, frame_last)
//   out       output      o_out_valid / i_out_stall o_out_data (verdict, cause, source_addr)
//   cfg       input       i_cfg_we                 i_cfg_idx, i_cfg_data
//
// the parser takes one frame byte per cycle; it stalls any byte while the
// four-entry request queue is full.
// for a monitored frame the session engine reads table entries one at a time until a match,
// at most the fill count (up to 64) of them, through the single read port of the session memory.
// reset is synchronous; clearing the fill count empties the session table at once.
// a result waits in the output register while the output is stalled; parsing carries on until the queue is full.
module mqtt_session_automaton_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  msaf_pkg::t_in_item                i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output msaf_pkg::t_out_item               o_out_data,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [msaf_pkg::CFG_W-1:0]        i_cfg_data
);

    msaf_pkg::t_cfg_write cfg;
    msaf_pkg::t_request   push_req;
    msaf_pkg::t_request   pop_req;
    logic                 push;
    logic                 q_full;
    logic                 q_valid;
    logic                 pop;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = msaf_pkg::t_cfg_idx'(i_cfg_idx);
    assign cfg.data = i_cfg_data;

    msaf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_req      (push_req)
    );

    msaf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_req),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (pop_req)
    );

    msaf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_req_valid (q_valid),
        .i_req       (pop_req),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

// ----- rtl/msaf_front.sv -----
// frame parser: captures header fields per byte and classifies each frame at its last byte
module msaf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  msaf_pkg::t_cfg_write  i_cfg,
    input  logic                  i_in_valid,
    input  msaf_pkg::t_in_item    i_in_data,
    output logic                  o_in_stall,
    input  logic                  i_q_full,
    output logic                  o_push,
    output msaf_pkg::t_request    o_req
);

    logic [msaf_pkg::POS_W-1:0] r_pos;
    logic                       r_eth_ok;
    logic                       r_proto_ok;
    logic                       r_mqtt_valid;
    logic [7:0]                 r_mqtt_byte;
    logic [31:0]                r_saddr;
    logic [15:0]                r_dport;
    logic [7:0]                 r_tcp [msaf_pkg::TCP_LEN];
    logic [15:0]                r_broker_port;

    logic                         accept;
    logic [7:0]                   b;
    logic [3:0]                   doff;
    logic [msaf_pkg::POS_W-1:0]   mqtt_off;
    logic [msaf_pkg::TCP_AW-1:0]  tcp_idx;
    logic                         in_tcp;
    logic                         at_mqtt;
    logic                         small_doff;
    logic                         have_mqtt;
    logic                         len_ok;
    logic [7:0]                   mqtt_byte;
    msaf_pkg::t_event             ev;

    assign b          = i_in_data.frame_byte;
    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign o_push     = accept && i_in_data.frame_last;

    assign doff     = r_tcp[msaf_pkg::DOFF_BYTE][7:4];
    assign mqtt_off = msaf_pkg::POS_W'(msaf_pkg::TCP_BASE) + msaf_pkg::POS_W'({doff, 2'b00});
    assign tcp_idx  = msaf_pkg::TCP_AW'(r_pos - msaf_pkg::POS_W'(msaf_pkg::TCP_BASE));
    assign in_tcp   = (r_pos >= msaf_pkg::POS_W'(msaf_pkg::TCP_BASE)) &&
                      (r_pos <  msaf_pkg::POS_W'(msaf_pkg::TCP_BASE + msaf_pkg::TCP_LEN));
    assign at_mqtt  = (r_pos >= msaf_pkg::POS_W'(msaf_pkg::TCP_BASE + msaf_pkg::TCP_LEN)) &&
                      (r_pos == mqtt_off);
    assign small_doff = doff < 4'(msaf_pkg::DOFF_SMALL);
    // frame must hold the full tcp header, so the last byte sits at 53 or later
    assign len_ok   = r_pos >= msaf_pkg::POS_W'(msaf_pkg::TCP_BASE + msaf_pkg::TCP_LEN - 1);

    // mqtt byte: inside the tcp header, captured earlier, or the last byte itself
    always_comb begin
        if (small_doff) begin
            have_mqtt = 1'b1;
            mqtt_byte = r_tcp[msaf_pkg::TCP_AW'({doff, 2'b00})];
        end else if (r_mqtt_valid) begin
            have_mqtt = 1'b1;
            mqtt_byte = r_mqtt_byte;
        end else begin
            have_mqtt = at_mqtt;
            mqtt_byte = b;
        end
    end

    always_comb begin
        case (mqtt_byte[7:4])
            msaf_pkg::MQTT_CONNECT:    ev = msaf_pkg::EV_CONNECT;
            msaf_pkg::MQTT_PUBLISH:    ev = msaf_pkg::EV_PUBLISH;
            msaf_pkg::MQTT_DISCONNECT: ev = msaf_pkg::EV_DISCONNECT;
            default:                   ev = msaf_pkg::EV_ERROR;
        endcase
    end

    assign o_req.track = len_ok && r_eth_ok && r_proto_ok &&
                         (r_dport == r_broker_port) && have_mqtt;
    assign o_req.saddr = r_saddr;
    assign o_req.ev    = ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_broker_port <= msaf_pkg::MQTT_PORT_DEFAULT;
        end else if (i_cfg.we && i_cfg.idx == msaf_pkg::CFG_BROKER_PORT) begin
            r_broker_port <= i_cfg.data[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_eth_ok     <= 1'b0;
            r_proto_ok   <= 1'b0;
            r_mqtt_valid <= 1'b0;
        end else if (accept) begin
            if (i_in_data.frame_last) begin
                r_pos        <= '0;
                r_eth_ok     <= 1'b0;
                r_proto_ok   <= 1'b0;
                r_mqtt_valid <= 1'b0;
            end else if (r_pos != msaf_pkg::POS_MAX) begin
                r_pos <= r_pos + 1'b1;
                if (r_pos == msaf_pkg::POS_W'(msaf_pkg::ETH_TYPE_POS)) begin
                    r_eth_ok <= (b == msaf_pkg::IPV4_ETHERTYPE[15:8]);
                end
                if (r_pos == msaf_pkg::POS_W'(msaf_pkg::ETH_TYPE_POS + 1) &&
                    b != msaf_pkg::IPV4_ETHERTYPE[7:0]) begin
                    r_eth_ok <= 1'b0;
                end
                if (r_pos == msaf_pkg::POS_W'(msaf_pkg::IP_PROTO_POS)) begin
                    r_proto_ok <= (b == msaf_pkg::TCP_PROTOCOL);
                end
                if (at_mqtt) begin
                    r_mqtt_valid <= 1'b1;
                end
            end
        end
    end

    // header payload, no reset: every field is rewritten before a full-length frame reads it
    always_ff @(posedge i_clk) begin
        if (accept && !i_in_data.frame_last && r_pos != msaf_pkg::POS_MAX) begin
            if (r_pos == msaf_pkg::POS_W'(msaf_pkg::SADDR_POS)) begin
                r_saddr[31:24] <= b;
            end
            if (r_pos == msaf_pkg::POS_W'(msaf_pkg::SADDR_POS + 1)) begin
                r_saddr[23:16] <= b;
            end
            if (r_pos == msaf_pkg::POS_W'(msaf_pkg::SADDR_POS + 2)) begin
                r_saddr[15:8] <= b;
            end
            if (r_pos == msaf_pkg::POS_W'(msaf_pkg::SADDR_POS + 3)) begin
                r_saddr[7:0] <= b;
            end
            if (r_pos == msaf_pkg::POS_W'(msaf_pkg::DPORT_POS)) begin
                r_dport[15:8] <= b;
            end
            if (r_pos == msaf_pkg::POS_W'(msaf_pkg::DPORT_POS + 1)) begin
                r_dport[7:0] <= b;
            end
            if (in_tcp) begin
                r_tcp[tcp_idx] <= b;
            end
            if (at_mqtt) begin
                r_mqtt_byte <= b;
            end
        end
    end

endmodule

// ----- rtl/msaf_queue.sv -----
// short request queue between the frame parser and the session engine
module msaf_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  msaf_pkg::t_request  i_data,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output msaf_pkg::t_request  o_data
);

    msaf_pkg::t_request            r_mem [msaf_pkg::QUEUE_DEPTH];
    logic [msaf_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [msaf_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [msaf_pkg::QUEUE_CW-1:0] r_count;

    assign o_full  = r_count == msaf_pkg::QUEUE_CW'(msaf_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == msaf_pkg::QUEUE_AW'(msaf_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == msaf_pkg::QUEUE_AW'(msaf_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("request queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("request queue read while empty");

endmodule

// ----- rtl/msaf_back.sv -----
// session engine: searches the session table, steps the automaton, registers the verdict
module msaf_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  msaf_pkg::t_cfg_write  i_cfg,
    input  logic                  i_req_valid,
    input  msaf_pkg::t_request    i_req,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output msaf_pkg::t_out_item   o_out,
    input  logic                  i_out_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_DECIDE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [31:0]                  addr;
        logic [msaf_pkg::STATE_W-1:0] state;
    } t_session;

    // session table: entries below the fill count are valid, filled in order
    t_session r_mem [msaf_pkg::SESSIONS];
    t_session r_rd;

    t_state                        r_state;
    msaf_pkg::t_request            r_req;
    logic [msaf_pkg::SESS_CW-1:0]  r_fill;
    logic [msaf_pkg::SESS_CW-1:0]  r_idx;
    logic                          r_hit;
    logic [msaf_pkg::STATE_W-1:0]  r_cur;
    msaf_pkg::t_out_item           r_res;
    logic                          r_out_valid;
    msaf_pkg::t_out_item           r_out;

    logic [msaf_pkg::CFG_W-1:0]    r_trans_low;
    logic [msaf_pkg::CFG_W-1:0]    r_trans_high;
    logic [msaf_pkg::STATE_W-1:0]  r_error_state;

    logic [msaf_pkg::STATE_W-1:0]  cur;
    logic [msaf_pkg::CFG_W-1:0]    tbl;
    logic [5:0]                    nib_sel;
    logic [3:0]                    nib;
    logic [msaf_pkg::STATE_W-1:0]  nxt;
    logic                          blocked;
    logic                          room;
    logic                          mem_we;
    logic [msaf_pkg::SESS_AW-1:0]  mem_waddr;
    t_session                      mem_wdata;

    assign cur     = r_hit ? r_cur : '0;
    assign tbl     = cur[2] ? r_trans_high : r_trans_low;
    assign nib_sel = {cur[1:0], r_req.ev, 2'b00};
    assign nib     = tbl[nib_sel +: 4];
    assign nxt     = (!nib[3] || {1'b0, nib[2:0]} >= 4'(msaf_pkg::NUM_STATES)) ?
                     r_error_state : nib[2:0];
    assign blocked = cur == r_error_state;
    assign room    = r_hit || (r_fill != msaf_pkg::SESS_CW'(msaf_pkg::SESSIONS));

    assign mem_we          = (r_state == S_DECIDE) && !blocked && room;
    assign mem_waddr       = r_hit ? r_idx[msaf_pkg::SESS_AW-1:0] : r_fill[msaf_pkg::SESS_AW-1:0];
    assign mem_wdata.addr  = r_req.saddr;
    assign mem_wdata.state = nxt;

    assign o_pop       = (r_state == S_IDLE) && i_req_valid;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[r_idx[msaf_pkg::SESS_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_low   <= '0;
            r_trans_high  <= '0;
            r_error_state <= '1;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                msaf_pkg::CFG_TRANS_LOW:   r_trans_low   <= i_cfg.data;
                msaf_pkg::CFG_TRANS_HIGH:  r_trans_high  <= i_cfg.data;
                msaf_pkg::CFG_ERROR_STATE: r_error_state <= i_cfg.data[msaf_pkg::STATE_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // in S_OUT the output register is handled by that state alone
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req             <= i_req;
                        r_idx             <= '0;
                        r_hit             <= 1'b0;
                        r_res.verdict     <= 1'b0;
                        r_res.cause       <= msaf_pkg::CAUSE_UNMONITORED;
                        r_res.source_addr <= '0;
                        r_state           <= i_req.track ? S_SCAN : S_OUT;
                    end
                end
                S_SCAN: begin
                    // read of entry r_idx is under way unless the valid entries are used up
                    r_state <= (r_idx == r_fill) ? S_DECIDE : S_CMP;
                end
                S_CMP: begin
                    if (r_rd.addr == r_req.saddr) begin
                        r_hit   <= 1'b1;
                        r_cur   <= r_rd.state;
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SCAN;
                    end
                end
                S_DECIDE: begin
                    if (!blocked && !r_hit && room) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_res.source_addr <= r_req.saddr;
                    if (blocked) begin
                        r_res.verdict <= 1'b1;
                        r_res.cause   <= msaf_pkg::CAUSE_BLOCKED;
                    end else if (nxt == r_error_state) begin
                        r_res.verdict <= 1'b1;
                        r_res.cause   <= msaf_pkg::CAUSE_NEW_BLOCK;
                    end else begin
                        r_res.verdict <= 1'b0;
                        r_res.cause   <= msaf_pkg::CAUSE_ALLOWED;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out       <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= msaf_pkg::SESS_CW'(msaf_pkg::SESSIONS))
        else $error("session fill count beyond table size");

    a_cmp_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ($past(r_state) == S_SCAN && r_idx < r_fill))
        else $error("compare without a read of a valid entry");

    a_verdict_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.verdict == (r_out.cause == msaf_pkg::CAUSE_BLOCKED ||
                                            r_out.cause == msaf_pkg::CAUSE_NEW_BLOCK)) &&
                         (r_out.cause != msaf_pkg::CAUSE_UNMONITORED ||
                          r_out.source_addr == '0)))
        else $error("verdict does not match cause");

endmodule
